// File: hdl/quaternion_vector_rotator_assert.svh
// Assertion macros used by the checker file qvr_checker.sv.
`ifndef QUATERNION_VECTOR_ROTATOR_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATOR_ASSERT_SVH

// cond must hold at every edge out of reset
`define QVR_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("qvr: invariant violated");

// ante implies cons at the same edge
`define QVR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr: implication violated");

// ante implies cons at a later edge, with the delay given by n
`define QVR_ASSERT_DELAYED(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("qvr: delayed implication violated");

`endif

// File: hdl/qvr_pkg.sv
`default_nettype none
package qvr_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int DATA_WIDTH      = 16;
  localparam int Q_WIDTH         = 16;
  localparam int C_WIDTH         = Q_WIDTH + 1;
  localparam int P1_WIDTH        = Q_WIDTH + DATA_WIDTH;
  localparam int A_WIDTH         = P1_WIDTH - FRAC_BITS + 2;
  localparam int P2_WIDTH        = A_WIDTH + C_WIDTH;
  localparam int R_WIDTH         = P2_WIDTH - FRAC_BITS + 2;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = Q_WIDTH;
  localparam int LATENCY         = 5;

  typedef logic signed [Q_WIDTH-1:0]    qval_t;
  typedef logic signed [C_WIDTH-1:0]    cval_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [P1_WIDTH-1:0]   prod1_t;
  typedef logic signed [A_WIDTH-1:0]    aval_t;
  typedef logic signed [P2_WIDTH-1:0]   prod2_t;
  typedef logic signed [R_WIDTH-1:0]    rval_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_Q_SCALAR,
    REG_Q_I,
    REG_Q_J,
    REG_Q_K
  } cfg_reg_t;

  localparam qval_t Q_SCALAR_RESET = 16'sd16384;
  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    qval_t s;
    qval_t i;
    qval_t j;
    qval_t k;
  } quat_t;

  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
  } vec_t;

  typedef struct packed {
    aval_t s;
    aval_t i;
    aval_t j;
    aval_t k;
  } avec_t;

  typedef struct packed {
    rval_t x;
    rval_t y;
    rval_t z;
  } rvec_t;

  typedef struct packed {
    logic  clip;
    data_t val;
  } sat_t;

  function automatic prod1_t mul1(qval_t a, data_t b);
    return P1_WIDTH'(a) * P1_WIDTH'(b);
  endfunction

  function automatic aval_t scale1(prod1_t p);
    return A_WIDTH'(signed'(p[P1_WIDTH-1:FRAC_BITS]));
  endfunction

  function automatic prod2_t mul2(aval_t a, cval_t c);
    return P2_WIDTH'(a) * P2_WIDTH'(c);
  endfunction

  function automatic rval_t scale2(prod2_t p);
    return R_WIDTH'(signed'(p[P2_WIDTH-1:FRAC_BITS]));
  endfunction

  function automatic sat_t saturate(rval_t r);
    logic [R_WIDTH-DATA_WIDTH:0] upper;
    sat_t res;
    upper = r[R_WIDTH-1:DATA_WIDTH-1];
    if (upper == '0 || upper == '1) begin
      res.clip = 1'b0;
      res.val  = r[DATA_WIDTH-1:0];
    end else begin
      res.clip = 1'b1;
      res.val  = r[R_WIDTH-1] ? DATA_MIN : DATA_MAX;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/qvr_fwd.sv
`default_nettype none
module qvr_fwd (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qvr_pkg::vec_t  vec,
  input  qvr_pkg::quat_t q,
  output logic           a_valid,
  output qvr_pkg::avec_t a
);
  import qvr_pkg::*;

  logic   p_valid;
  prod1_t p_ix, p_jy, p_kz;
  prod1_t p_sx, p_jz, p_ky;
  prod1_t p_sy, p_iz, p_kx;
  prod1_t p_sz, p_iy, p_jx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      a_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
      a_valid <= p_valid;
    end
  end

  // q * (0,v)
  always_ff @(posedge clk) begin
    p_ix <= mul1(q.i, vec.x);
    p_jy <= mul1(q.j, vec.y);
    p_kz <= mul1(q.k, vec.z);
    p_sx <= mul1(q.s, vec.x);
    p_jz <= mul1(q.j, vec.z);
    p_ky <= mul1(q.k, vec.y);
    p_sy <= mul1(q.s, vec.y);
    p_iz <= mul1(q.i, vec.z);
    p_kx <= mul1(q.k, vec.x);
    p_sz <= mul1(q.s, vec.z);
    p_iy <= mul1(q.i, vec.y);
    p_jx <= mul1(q.j, vec.x);
  end

  always_ff @(posedge clk) begin
    a.s <= -scale1(p_ix) - scale1(p_jy) - scale1(p_kz);
    a.i <=  scale1(p_sx) + scale1(p_jz) - scale1(p_ky);
    a.j <=  scale1(p_sy) - scale1(p_iz) + scale1(p_kx);
    a.k <=  scale1(p_sz) + scale1(p_iy) - scale1(p_jx);
  end

endmodule
`default_nettype wire

// File: hdl/qvr_back.sv
`default_nettype none
module qvr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           a_valid,
  input  qvr_pkg::avec_t a,
  input  qvr_pkg::quat_t q,
  output logic           r_valid,
  output qvr_pkg::rvec_t r
);
  import qvr_pkg::*;

  logic   p_valid;
  cval_t  cs, ci, cj, ck;
  prod2_t p_si, p_is, p_jk, p_kj;
  prod2_t p_sj, p_ik, p_js, p_ki;
  prod2_t p_sk, p_ij, p_ji, p_ks;

  // conjugate, one bit wider so the most negative part negates exactly
  always_comb begin
    cs = C_WIDTH'(q.s);
    ci = -C_WIDTH'(q.i);
    cj = -C_WIDTH'(q.j);
    ck = -C_WIDTH'(q.k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      p_valid <= a_valid;
      r_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_si <= mul2(a.s, ci);
    p_is <= mul2(a.i, cs);
    p_jk <= mul2(a.j, ck);
    p_kj <= mul2(a.k, cj);
    p_sj <= mul2(a.s, cj);
    p_ik <= mul2(a.i, ck);
    p_js <= mul2(a.j, cs);
    p_ki <= mul2(a.k, ci);
    p_sk <= mul2(a.s, ck);
    p_ij <= mul2(a.i, cj);
    p_ji <= mul2(a.j, ci);
    p_ks <= mul2(a.k, cs);
  end

  always_ff @(posedge clk) begin
    r.x <= scale2(p_si) + scale2(p_is) + scale2(p_jk) - scale2(p_kj);
    r.y <= scale2(p_sj) - scale2(p_ik) + scale2(p_js) + scale2(p_ki);
    r.z <= scale2(p_sk) + scale2(p_ij) - scale2(p_ji) + scale2(p_ks);
  end

endmodule
`default_nettype wire

// File: hdl/qvr_sat.sv
`default_nettype none
module qvr_sat (
  input  logic           clk,
  input  logic           rst,
  input  logic           r_valid,
  input  qvr_pkg::rvec_t r,
  output logic           done,
  output qvr_pkg::data_t rot_x,
  output qvr_pkg::data_t rot_y,
  output qvr_pkg::data_t rot_z,
  output logic           clipped
);
  import qvr_pkg::*;

  sat_t sx, sy, sz;

  always_comb begin
    sx = saturate(r.x);
    sy = saturate(r.y);
    sz = saturate(r.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    rot_x   <= sx.val;
    rot_y   <= sy.val;
    rot_z   <= sz.val;
    clipped <= sx.clip | sy.clip | sz.clip;
  end

endmodule
`default_nettype wire

// File: hdl/quaternion_vector_rotator.sv
`default_nettype none
// Quaternion vector rotator.
// Configuration: cfg_we writes cfg_data into register cfg_index at a clock
// edge (0 q_scalar, 1 q_i, 2 q_j, 3 q_k, all Q2.14). Write only while no
// word is in flight.
// Input: a word (vec_x, vec_y, vec_z) is taken at each edge where start is
// high and busy is low. busy stays low, so a word may enter every cycle.
// Output: the rotated word appears on rot_x, rot_y, rot_z and clipped with
// done high for exactly one cycle. Throughput is one word per cycle, set by
// the fully pipelined multiplier array: twelve products, sum, twelve products,
// sum, saturate, each behind a register.
// clipped is high when any component hit the 16-bit rails.
// Reset (rst, synchronous) empties the pipeline and loads the identity
// quaternion. The receiver must take each word in the cycle it is shown.
module quaternion_vector_rotator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  qvr_pkg::data_t                        vec_x,
  input  qvr_pkg::data_t                        vec_y,
  input  qvr_pkg::data_t                        vec_z,
  input  logic                                  cfg_we,
  input  logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [qvr_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  output logic                                  done,
  output qvr_pkg::data_t                        rot_x,
  output qvr_pkg::data_t                        rot_y,
  output qvr_pkg::data_t                        rot_z,
  output logic                                  clipped
);
  import qvr_pkg::*;

  quat_t q;
  vec_t  vec;
  logic  a_valid;
  avec_t a;
  logic  r_valid;
  rvec_t r;

  assign busy = 1'b0;

  always_comb begin
    vec.x = vec_x;
    vec.y = vec_y;
    vec.z = vec_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.s <= Q_SCALAR_RESET;
      q.i <= '0;
      q.j <= '0;
      q.k <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_Q_SCALAR: q.s <= cfg_data;
        REG_Q_I:      q.i <= cfg_data;
        REG_Q_J:      q.j <= cfg_data;
        REG_Q_K:      q.k <= cfg_data;
        default: ;
      endcase
    end
  end

  qvr_fwd u_fwd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .vec      (vec),
    .q        (q),
    .a_valid  (a_valid),
    .a        (a)
  );

  qvr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .a_valid (a_valid),
    .a       (a),
    .q       (q),
    .r_valid (r_valid),
    .r       (r)
  );

  qvr_sat u_sat (
    .clk     (clk),
    .rst     (rst),
    .r_valid (r_valid),
    .r       (r),
    .done    (done),
    .rot_x   (rot_x),
    .rot_y   (rot_y),
    .rot_z   (rot_z),
    .clipped (clipped)
  );

endmodule
`default_nettype wire

// File: hdl/qvr_checker.sv
`default_nettype none
`include "quaternion_vector_rotator_assert.svh"
module qvr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done,
  input wire qvr_pkg::data_t rot_x,
  input wire qvr_pkg::data_t rot_y,
  input wire qvr_pkg::data_t rot_z,
  input wire logic           clipped
);
  import qvr_pkg::*;

  `QVR_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `QVR_ASSERT_DELAYED(a_word_out, clk, rst, start && !busy, 5, done)
  `QVR_ASSERT_IMPLIES(a_no_stray, clk, rst, done, $past(start && !busy, 5))
  `QVR_ASSERT_IMPLIES(a_clip_rail, clk, rst, done && clipped, rot_x == DATA_MAX || rot_x == DATA_MIN || rot_y == DATA_MAX || rot_y == DATA_MIN || rot_z == DATA_MAX || rot_z == DATA_MIN)

endmodule

bind quaternion_vector_rotator qvr_checker u_qvr_checker (.*);
`default_nettype wire
